>>> design/pcuf_pkg.sv
// Package with the lattice constants, entry encoding and controller states.
`timescale 1ns / 1ps
package pcuf_pkg;

   // Lattice geometry; the side is a power of two so the column is a mask.
   localparam int SIDE    = 128;
   localparam int NSITES  = SIDE * SIDE;
   localparam int COL_W   = $clog2(SIDE);
   localparam int SITE_W  = 14;
   localparam int CNT_W   = 15;
   localparam int ENTRY_W = 16;

   typedef logic signed [ENTRY_W-1:0] entry_type;
   typedef logic [SITE_W-1:0]         site_type;
   typedef logic [CNT_W-1:0]          count_type;

   // Empty marker is minus the site count minus one.
   localparam entry_type EMPTY_MARK = ENTRY_W'(-NSITES - 1);
   localparam entry_type SIZE_ONE   = ENTRY_W'(-1);

   localparam logic OP_OCCUPY = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SITE_CHK,
      ST_NB_RD,
      ST_NB_CHK,
      ST_FIND_CHK,
      ST_COMP_RD,
      ST_COMP_CHK,
      ST_UNION_A,
      ST_UNION_B,
      ST_FINISH,
      ST_RESP
   } state_type;

   // One access to the site table.
   typedef struct packed {
      logic      we;
      site_type  addr;
      entry_type wdata;
   } ram_req_type;

endpackage

>>> design/pcuf_if.sv
// Valid/ready channel interfaces for the request and response words.
`timescale 1ns / 1ps
interface pcuf_req_if import pcuf_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     op;
   site_type site;

   modport source (output valid, output op, output site, input ready);
   modport sink   (input valid, input op, input site, output ready);
endinterface

interface pcuf_rsp_if import pcuf_pkg::*; ();
   logic      valid;
   logic      ready;
   count_type occupied_count;
   count_type largest_cluster;
   count_type joined_cluster_size;
   logic      already_occupied;

   modport source (output valid, output occupied_count, output largest_cluster,
                   output joined_cluster_size, output already_occupied, input ready);
   modport sink   (input valid, input occupied_count, input largest_cluster,
                   input joined_cluster_size, input already_occupied, output ready);
endinterface

>>> design/pcuf_ram.sv
// Generic single-port RAM with a registered read port.
`timescale 1ns / 1ps
module pcuf_ram #(
   parameter int DEPTH  = 16384,
   parameter int WIDTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Read-first port: a read of the address being written returns the old entry.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/percolation_cluster_union_find.sv
// Site percolation cluster builder: union-find over a periodic square lattice.
//
// Usage: a request word carries op and site on req_ch; each request gives
// exactly one response word on rsp_ch with the occupied count, the largest
// cluster size, the size of the cluster the new site joined and a flag for
// an occupy of a site that was already occupied.
// The union-find table lives in one single-port RAM with a registered read
// port; every step of a root walk, a path compression and a union is a
// RAM access, so the RAM port sets the rate. An occupy reads the site, then
// for each of the four neighbors reads it and, when it is occupied, walks
// to its root, compresses the path and unites the two roots by size; an
// occupy of an occupied site only reads the site.
// A clear request, and reset, sweep all NSITES (16384) entries of the table
// one entry a cycle; no request is taken during the sweep.
// One request is worked on at a time. The response sits in an output
// register, so the next request is taken while it waits; if the receiver
// stalls, the following response waits in the controller until the
// register frees up.
`timescale 1ns / 1ps
module percolation_cluster_union_find import pcuf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pcuf_req_if.sink    req_ch,
   pcuf_rsp_if.source  rsp_ch
);

   state_type   state_ff, state_in;
   site_type    cnt_ff, cnt_in;
   logic        clr_rsp_ff, clr_rsp_in;
   site_type    s_ff, s_in;
   logic [1:0]  dir_ff, dir_in;
   site_type    nb_ff, nb_in;
   site_type    cur_ff, cur_in;
   site_type    comp_ff, comp_in;
   site_type    r1_ff, r1_in;
   entry_type   r1v_ff, r1v_in;
   site_type    r2_ff, r2_in;
   entry_type   r2v_ff, r2v_in;
   count_type   occ_ff, occ_in;
   count_type   large_ff, large_in;
   count_type   joined_ff, joined_in;
   logic        flag_ff, flag_in;
   logic        rsp_valid_ff, rsp_valid_in;
   count_type   rsp_occ_ff, rsp_occ_in;
   count_type   rsp_large_ff, rsp_large_in;
   count_type   rsp_joined_ff, rsp_joined_in;
   logic        rsp_flag_ff, rsp_flag_in;

   ram_req_type ram_req;
   entry_type   rdata;
   logic [ENTRY_W-1:0] rdata_raw;
   logic        req_fire;
   logic        out_free;
   logic        r1_smaller;
   entry_type   size_sum;
   site_type    nb_addr;

   pcuf_ram #(.DEPTH(NSITES), .WIDTH(ENTRY_W), .ADDR_W(SITE_W)) u_ram (
      .clock (clock),
      .we    (ram_req.we),
      .addr  (ram_req.addr),
      .wdata (ram_req.wdata),
      .rdata (rdata_raw)
   );

   assign rdata = entry_type'(rdata_raw);

   // Neighbor of the current site in one of the four directions.
   function automatic site_type neighbor(site_type s, logic [1:0] d);
      logic [COL_W-1:0] col;
      logic [SITE_W:0]  wide;
      col  = s[COL_W-1:0];
      wide = '0;
      unique case (d)
         2'd0: wide = (col == COL_W'(SIDE - 1)) ? {1'b0, s} + 1'b1 - (SITE_W+1)'(SIDE)
                                                 : {1'b0, s} + 1'b1;
         2'd1: wide = (col == '0) ? {1'b0, s} + (SITE_W+1)'(SIDE) - 1'b1
                                  : {1'b0, s} - 1'b1;
         2'd2: begin
            wide = {1'b0, s} + (SITE_W+1)'(SIDE);
            if (wide >= (SITE_W+1)'(NSITES)) wide = wide - (SITE_W+1)'(NSITES);
         end
         default: begin
            wide = {1'b0, s} + (SITE_W+1)'(NSITES) - (SITE_W+1)'(SIDE);
            if (wide >= (SITE_W+1)'(NSITES)) wide = wide - (SITE_W+1)'(NSITES);
         end
      endcase
      return wide[SITE_W-1:0];
   endfunction

   assign req_fire   = req_ch.valid && req_ch.ready;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign r1_smaller = r1v_ff > r2v_ff;
   assign size_sum   = r1v_ff + r2v_ff;
   assign nb_addr    = neighbor(s_ff, dir_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == SITE_W'(NSITES - 1)) state_in = clr_rsp_ff ? ST_RESP : ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.op == OP_CLEAR) state_in = ST_CLEAR;
               else if ({1'b0, req_ch.site} >= (SITE_W+1)'(NSITES)) state_in = ST_RESP;
               else state_in = ST_SITE_CHK;
            end
         end
         ST_SITE_CHK: state_in = (rdata != EMPTY_MARK) ? ST_RESP : ST_NB_RD;
         ST_NB_RD:    state_in = ST_NB_CHK;
         ST_NB_CHK: begin
            priority if (rdata == EMPTY_MARK) state_in = (dir_ff == 2'd3) ? ST_FINISH : ST_NB_RD;
            else if (rdata[ENTRY_W-1])        state_in = ST_COMP_RD;
            else                              state_in = ST_FIND_CHK;
         end
         ST_FIND_CHK: state_in = rdata[ENTRY_W-1] ? ST_COMP_RD : ST_FIND_CHK;
         ST_COMP_RD:  state_in = (comp_ff == r2_ff) ? ST_UNION_A : ST_COMP_CHK;
         ST_COMP_CHK: state_in = rdata[ENTRY_W-1] ? ST_UNION_A : ST_COMP_RD;
         ST_UNION_A: begin
            priority if (r2_ff != r1_ff) state_in = ST_UNION_B;
            else state_in = (dir_ff == 2'd3) ? ST_FINISH : ST_NB_RD;
         end
         ST_UNION_B:  state_in = (dir_ff == 2'd3) ? ST_FINISH : ST_NB_RD;
         ST_FINISH:   state_in = ST_RESP;
         ST_RESP:     state_in = out_free ? ST_IDLE : ST_RESP;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath, RAM access and response loading per state.
   always_comb begin
      cnt_in        = cnt_ff;
      clr_rsp_in    = clr_rsp_ff;
      s_in          = s_ff;
      dir_in        = dir_ff;
      nb_in         = nb_ff;
      cur_in        = cur_ff;
      comp_in       = comp_ff;
      r1_in         = r1_ff;
      r1v_in        = r1v_ff;
      r2_in         = r2_ff;
      r2v_in        = r2v_ff;
      occ_in        = occ_ff;
      large_in      = large_ff;
      joined_in     = joined_ff;
      flag_in       = flag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_occ_in    = rsp_occ_ff;
      rsp_large_in  = rsp_large_ff;
      rsp_joined_in = rsp_joined_ff;
      rsp_flag_in   = rsp_flag_ff;
      ram_req       = '{we: 1'b0, addr: s_ff, wdata: EMPTY_MARK};

      unique case (state_ff)
         ST_CLEAR: begin
            ram_req  = '{we: 1'b1, addr: cnt_ff, wdata: EMPTY_MARK};
            cnt_in   = cnt_ff + 1'b1;
            occ_in   = '0;
            large_in = '0;
         end
         ST_IDLE: begin
            cnt_in    = '0;
            joined_in = '0;
            flag_in   = 1'b0;
            s_in      = req_ch.site;
            clr_rsp_in = 1'b1;
            ram_req   = '{we: 1'b0, addr: req_ch.site, wdata: EMPTY_MARK};
         end
         ST_SITE_CHK: begin
            if (rdata != EMPTY_MARK) begin
               flag_in = 1'b1;
            end else begin
               ram_req = '{we: 1'b1, addr: s_ff, wdata: SIZE_ONE};
               occ_in  = occ_ff + 1'b1;
               r1_in   = s_ff;
               r1v_in  = SIZE_ONE;
               dir_in  = 2'd0;
            end
         end
         ST_NB_RD: begin
            ram_req = '{we: 1'b0, addr: nb_addr, wdata: EMPTY_MARK};
            nb_in   = nb_addr;
            cur_in  = nb_addr;
         end
         ST_NB_CHK, ST_FIND_CHK: begin
            priority if (state_ff == ST_NB_CHK && rdata == EMPTY_MARK) begin
               dir_in = dir_ff + 1'b1;
            end else if (rdata[ENTRY_W-1]) begin
               r2_in   = cur_ff;
               r2v_in  = rdata;
               comp_in = nb_ff;
            end else begin
               cur_in  = rdata[SITE_W-1:0];
               ram_req = '{we: 1'b0, addr: rdata[SITE_W-1:0], wdata: EMPTY_MARK};
            end
         end
         ST_COMP_RD: begin
            ram_req = '{we: 1'b0, addr: comp_ff, wdata: EMPTY_MARK};
         end
         ST_COMP_CHK: begin
            if (!rdata[ENTRY_W-1]) begin
               ram_req = '{we: 1'b1, addr: comp_ff, wdata: ENTRY_W'(r2_ff)};
               comp_in = rdata[SITE_W-1:0];
            end
         end
         ST_UNION_A: begin
            // Root that stays a root takes the combined size.
            if (r2_ff != r1_ff) begin
               ram_req = '{we: 1'b1, addr: r1_smaller ? r2_ff : r1_ff, wdata: size_sum};
            end else begin
               dir_in = dir_ff + 1'b1;
            end
         end
         ST_UNION_B: begin
            // The smaller root points at the larger; ties keep the new site's root.
            if (r1_smaller) begin
               ram_req = '{we: 1'b1, addr: r1_ff, wdata: ENTRY_W'(r2_ff)};
               r1_in   = r2_ff;
            end else begin
               ram_req = '{we: 1'b1, addr: r2_ff, wdata: ENTRY_W'(r1_ff)};
            end
            r1v_in = size_sum;
            dir_in = dir_ff + 1'b1;
         end
         ST_FINISH: begin
            joined_in = CNT_W'(-r1v_ff);
            if (CNT_W'(-r1v_ff) > large_ff) large_in = CNT_W'(-r1v_ff);
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_occ_in    = occ_ff;
               rsp_large_in  = large_ff;
               rsp_joined_in = joined_ff;
               rsp_flag_in   = flag_ff;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         occ_ff       <= '0;
         large_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         occ_ff       <= occ_in;
         large_ff     <= large_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      s_ff          <= s_in;
      dir_ff        <= dir_in;
      nb_ff         <= nb_in;
      cur_ff        <= cur_in;
      comp_ff       <= comp_in;
      r1_ff         <= r1_in;
      r1v_ff        <= r1v_in;
      r2_ff         <= r2_in;
      r2v_ff        <= r2v_in;
      joined_ff     <= joined_in;
      flag_ff       <= flag_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_large_ff  <= rsp_large_in;
      rsp_joined_ff <= rsp_joined_in;
      rsp_flag_ff   <= rsp_flag_in;
   end

   assign req_ch.ready               = (state_ff == ST_IDLE);
   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.occupied_count      = rsp_occ_ff;
   assign rsp_ch.largest_cluster     = rsp_large_ff;
   assign rsp_ch.joined_cluster_size = rsp_joined_ff;
   assign rsp_ch.already_occupied    = rsp_flag_ff;

endmodule

>>> design/pcuf_checker.sv
// Port-level checker for the cluster builder and its bind statement.
`timescale 1ns / 1ps
module pcuf_checker import pcuf_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input count_type occupied_count,
   input count_type largest_cluster,
   input count_type joined_cluster_size,
   input logic      already_occupied
);

   // A stalled response word stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   // The table sweep after reset blocks requests.
   a_reset_sweep: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during the reset sweep");

   // An ignored occupy joins nothing.
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && already_occupied |-> joined_cluster_size == '0)
      else $error("ignored occupy reports a cluster size");

   // No cluster exceeds the largest, and the largest never exceeds the occupied count.
   a_sizes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> joined_cluster_size <= largest_cluster
                    && largest_cluster <= occupied_count)
      else $error("cluster sizes out of order");

endmodule

bind percolation_cluster_union_find pcuf_checker u_pcuf_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .occupied_count      (rsp_ch.occupied_count),
   .largest_cluster     (rsp_ch.largest_cluster),
   .joined_cluster_size (rsp_ch.joined_cluster_size),
   .already_occupied    (rsp_ch.already_occupied)
);

>>> bench/percolation_cluster_union_find_tb.sv
// Testbench for the percolation cluster builder: directed table, then random occupies and clears.
`timescale 1ns / 1ps
module percolation_cluster_union_find_tb;
   import pcuf_pkg::*;

   localparam int EMPTY_SIZE = -NSITES - 1;
   localparam int WATCHDOG_LIMIT = 80000;
   localparam int RANDOM_ITEMS = 880;

   // One result word as the block reports it.
   typedef struct {
      count_type occupied_count;
      count_type largest_cluster;
      count_type joined_cluster_size;
      logic      already_occupied;
   } cluster_report;

   // One row of the directed table; typed rows carry their own expected word.
   typedef struct {
      logic op;
      int   site;
      bit   typed;
      int   occ;
      int   big;
      int   joined;
      bit   flag;
   } step_row;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pcuf_req_if req_ch ();
   pcuf_rsp_if rsp_ch ();

   percolation_cluster_union_find uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // Shadow copy of the site table and the two counters.
   int lattice [NSITES];
   int occupied_sites;
   int biggest_cluster;

   cluster_report expected_reports [$];
   int  mismatches = 0;
   int  idle_pct = 0;
   int  stall_pct = 0;
   int  hold_cycles = 0;
   int  quiet_cycles = 0;
   bit  typed_pending [$];
   cluster_report typed_reports [$];

   step_row directed_rows [] = '{
      '{OP_OCCUPY, 0,     1, 1, 1, 1, 0},
      '{OP_OCCUPY, 0,     1, 1, 1, 0, 1},
      '{OP_OCCUPY, 127,   0, 0, 0, 0, 0},
      '{OP_OCCUPY, 16256, 0, 0, 0, 0, 0},
      '{OP_OCCUPY, 128,   0, 0, 0, 0, 0},
      '{OP_OCCUPY, 1,     0, 0, 0, 0, 0},
      '{OP_OCCUPY, 16383, 0, 0, 0, 0, 0},
      '{OP_OCCUPY, 16383, 0, 0, 0, 0, 0},
      '{OP_OCCUPY, 8000,  0, 0, 0, 0, 0},
      '{OP_CLEAR,  0,     1, 0, 0, 0, 0},
      '{OP_OCCUPY, 16383, 1, 1, 1, 1, 0},
      '{OP_OCCUPY, 8191,  0, 0, 0, 0, 0},
      '{OP_OCCUPY, 5461,  0, 0, 0, 0, 0},
      '{OP_OCCUPY, 10922, 0, 0, 0, 0, 0},
      '{OP_OCCUPY, 16255, 0, 0, 0, 0, 0},
      '{OP_CLEAR,  16383, 1, 0, 0, 0, 0}
   };

   function automatic void empty_lattice();
      foreach (lattice[k]) lattice[k] = EMPTY_SIZE;
      occupied_sites = 0;
      biggest_cluster = 0;
   endfunction

   // Root walk followed by full path compression.
   function automatic int cluster_root(int s);
      int r;
      int p;
      r = s;
      while (lattice[r] >= 0) r = lattice[r];
      while (s != r && lattice[s] >= 0) begin
         p = lattice[s];
         lattice[s] = r;
         s = p;
      end
      return r;
   endfunction

   function automatic int next_site(int s, int dir);
      int col;
      col = s % SIDE;
      case (dir)
         0: return (col == SIDE - 1) ? s + 1 - SIDE : s + 1;
         1: return (col == 0) ? s + SIDE - 1 : s - 1;
         2: return (s + SIDE) % NSITES;
         default: return (s + NSITES - SIDE) % NSITES;
      endcase
   endfunction

   // Occupy or clear, merging the new site with its occupied neighbors by size.
   function automatic cluster_report grow_cluster(logic op, int s);
      cluster_report rep;
      int r1;
      int r2;
      int nb;
      int joined;
      joined = 0;
      rep.already_occupied = 1'b0;
      if (op == OP_CLEAR) begin
         empty_lattice();
      end else if (lattice[s] != EMPTY_SIZE) begin
         rep.already_occupied = 1'b1;
      end else begin
         r1 = s;
         lattice[s] = -1;
         occupied_sites++;
         for (int d = 0; d < 4; d++) begin
            nb = next_site(s, d);
            if (lattice[nb] != EMPTY_SIZE) begin
               r2 = cluster_root(nb);
               if (r2 != r1) begin
                  if (lattice[r1] > lattice[r2]) begin
                     lattice[r2] += lattice[r1];
                     lattice[r1] = r2;
                     r1 = r2;
                  end else begin
                     lattice[r1] += lattice[r2];
                     lattice[r2] = r1;
                  end
               end
            end
         end
         joined = -lattice[r1];
         if (joined > biggest_cluster) biggest_cluster = joined;
      end
      rep.occupied_count = count_type'(occupied_sites);
      rep.largest_cluster = count_type'(biggest_cluster);
      rep.joined_cluster_size = count_type'(joined);
      return rep;
   endfunction

   // Offer one word, idling first at the phase's rate, and wait for acceptance.
   task automatic send_word(logic op, int s);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.site <= site_type'(s);
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_row(step_row row);
      cluster_report rep;
      typed_pending.push_back(row.typed);
      rep.occupied_count = count_type'(row.occ);
      rep.largest_cluster = count_type'(row.big);
      rep.joined_cluster_size = count_type'(row.joined);
      rep.already_occupied = row.flag;
      typed_reports.push_back(rep);
      send_word(row.op, row.site);
   endtask

   // Predict on each accepted request word; typed rows override the prediction.
   always @(posedge clock) begin
      cluster_report rep;
      if (!reset && req_ch.valid && req_ch.ready) begin
         rep = grow_cluster(req_ch.op, int'(req_ch.site));
         if (typed_pending.size() > 0) begin
            if (typed_pending.pop_front()) rep = typed_reports.pop_front();
            else void'(typed_reports.pop_front());
         end
         expected_reports.push_back(rep);
      end
   end

   // Compare each accepted response word with the oldest expectation.
   always @(posedge clock) begin
      cluster_report want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_reports.size() == 0) begin
            $error("unexpected response word");
            mismatches++;
         end else begin
            want = expected_reports.pop_front();
            if (rsp_ch.occupied_count !== want.occupied_count) begin
               $error("occupied_count: expected %0d, got %0d",
                      want.occupied_count, rsp_ch.occupied_count);
               mismatches++;
            end
            if (rsp_ch.largest_cluster !== want.largest_cluster) begin
               $error("largest_cluster: expected %0d, got %0d",
                      want.largest_cluster, rsp_ch.largest_cluster);
               mismatches++;
            end
            if (rsp_ch.joined_cluster_size !== want.joined_cluster_size) begin
               $error("joined_cluster_size: expected %0d, got %0d",
                      want.joined_cluster_size, rsp_ch.joined_cluster_size);
               mismatches++;
            end
            if (rsp_ch.already_occupied !== want.already_occupied) begin
               $error("already_occupied: expected %0d, got %0d",
                      want.already_occupied, rsp_ch.already_occupied);
               mismatches++;
            end
         end
      end
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog on cycles without any accepted word; a clear sweep fits well inside.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int base_row;
      int base_col;
      int s;
      logic op;
      req_ch.valid = 1'b0;
      req_ch.op = OP_OCCUPY;
      req_ch.site = '0;
      rsp_ch.ready = 1'b0;
      empty_lattice();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_row(directed_rows[i]);

      base_row = 0;
      base_col = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // Idling phases: none, sender idle, receiver stalling, both.
         case (i * 4 / RANDOM_ITEMS)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 75; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 75; end
            default: begin idle_pct = 33; stall_pct = 33; end
         endcase
         if (i == 100) hold_cycles = 400;
         // Let the pipeline drain completely once in mid-run; the last word
         // is withdrawn so that it is not taken a second time.
         if (i == 450) begin
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (expected_reports.size() != 0);
         end
         // Move the working window now and then; windows may wrap the edges.
         if (i % 60 == 0) begin
            base_row = $urandom_range(SIDE - 1);
            base_col = $urandom_range(SIDE - 1);
         end
         op = OP_OCCUPY;
         if ($urandom_range(149) == 0) begin
            op = OP_CLEAR;
            s = $urandom_range(NSITES - 1);
         end else if ($urandom_range(9) == 0) begin
            s = $urandom_range(NSITES - 1);
         end else begin
            s = ((base_row + $urandom_range(7)) % SIDE) * SIDE
                + (base_col + $urandom_range(7)) % SIDE;
         end
         typed_pending.push_back(1'b0);
         typed_reports.push_back('{default: '0});
         send_word(op, s);
      end
      req_ch.valid <= 1'b0;

      while (expected_reports.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
